// ----- sv/kbm_pkg.sv -----
// Package for the multi-word multiplier: widths, counts and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kbm_pkg;
   localparam int WordBits   = 32;
   localparam int OpWords    = 16;
   localparam int ProdWords  = 2 * OpWords;
   localparam int IdxBits    = $clog2(OpWords);
   localparam int PIdxBits   = $clog2(ProdWords);
   localparam int UsedBits   = 6;
   // one spare cell on top takes the carry word of each row
   localparam int CellCount  = OpWords + 1;

   typedef logic [WordBits-1:0] word_type;

   typedef enum logic [3:0] {
      ST_LOAD = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_OUT  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // control from sequencer to every cell
   typedef struct packed {
      logic clear;   // zero the accumulator row
      logic mac;     // add a_i * b word in this cycle
      logic shift;   // move the row down one word
   } cell_ctl_type;
endpackage
`default_nettype wire

// ----- sv/kbm_cell.sv -----
// One cell of the product row: holds one accumulator word, adds its share of a
// word product and passes carry to the next cell. Uses kbm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kbm_cell (
   input  wire                    clock,
   input  kbm_pkg::cell_ctl_type  ctl,
   input  kbm_pkg::word_type      b_word,    // operand B word held by this cell
   input  kbm_pkg::word_type      a_bcast,   // current operand A word
   input  kbm_pkg::word_type      carry_in,  // high word from the cell below
   input  kbm_pkg::word_type      upper_acc, // accumulator of the cell above
   output kbm_pkg::word_type      acc,
   output kbm_pkg::word_type      carry_out
);
   import kbm_pkg::*;

   word_type acc_ff, acc_in;
   word_type hi_ff, hi_in;
   logic [2*WordBits-1:0] prod;
   logic [2*WordBits:0]   sum;

   always_comb begin
      prod   = {{WordBits{1'b0}}, a_bcast} * {{WordBits{1'b0}}, b_word};
      sum    = {1'b0, prod} + {{(WordBits+1){1'b0}}, acc_ff}
             + {{(WordBits+1){1'b0}}, carry_in};
      acc_in = acc_ff;
      hi_in  = hi_ff;
      if (ctl.clear) begin
         acc_in = '0;
         hi_in  = '0;
      end else if (ctl.mac) begin
         acc_in = sum[WordBits-1:0];
         hi_in  = sum[2*WordBits-1:WordBits];
      end else if (ctl.shift) begin
         acc_in = upper_acc;
         hi_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      hi_ff  <= hi_in;
   end

   assign acc       = acc_ff;
   assign carry_out = hi_ff;
endmodule
`default_nettype wire

// ----- sv/karatsuba_bignum_multiply_top.sv -----
// Multi-word multiplier top level: operand load, cell row and product output.
// Uses kbm_pkg and kbm_cell.
// After the last pair the sequencer multiplies row by row (ST_MUL); then the 2*OpWords
// product words follow on consecutive cycles (ST_OUT) and it returns to ST_LOAD via
// ST_DONE. Other pairs load one per cycle. Busy is high from the last pair to ST_LOAD.
// Reset clears load index and sequencer; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module karatsuba_bignum_multiply_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  kbm_pkg::word_type  req_a_word,
   input  kbm_pkg::word_type  req_b_word,
   input  wire                req_last_pair,
   output logic               rsp_valid,
   output kbm_pkg::word_type  rsp_product_word,
   output logic               rsp_last_word,
   output logic [5:0]         rsp_used_words
);
   import kbm_pkg::*;

   // The row is a carry-save chain: row i of the schoolbook product enters as a
   // broadcast of a[i]; carries ripple one cell per cycle, so each row takes mac
   // steps until its carries drain, then the row shifts and the low word retires.
   state_type         st_ff, st_in;
   logic [IdxBits:0]  load_ff, load_in;
   word_type          a_ff [OpWords];
   word_type          b_ff [OpWords];
   logic [IdxBits:0]  row_ff, row_in;
   logic [IdxBits:0]  step_ff, step_in;
   word_type          low_ff [OpWords];   // retired low product words
   logic [PIdxBits:0] out_ff, out_in;
   logic [UsedBits-1:0] used_ff, used_in;
   cell_ctl_type      ctl;
   word_type          acc [CellCount];
   word_type          cout [CellCount];
   word_type          a_cur;
   logic              accept;

   assign accept = start && !busy;
   assign busy   = (st_ff != ST_LOAD);
   assign a_cur  = (step_ff == '0) ? a_ff[row_ff[IdxBits-1:0]] : '0;

   always_comb begin
      ctl.clear = 1'b0;
      ctl.mac   = 1'b0;
      ctl.shift = 1'b0;
      if (st_ff == ST_LOAD && accept && req_last_pair) ctl.clear = 1'b1;
      if (st_ff == ST_MUL) begin
         if (step_ff == (IdxBits+1)'(OpWords+1))
            ctl.shift = 1'b1;
         else
            ctl.mac = 1'b1;
      end
   end

   genvar g;
   generate
      for (g = 0; g < CellCount; g++) begin : g_row
         kbm_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .b_word    ((g == OpWords) ? word_type'(0) : b_ff[(g == OpWords) ? 0 : g]),
            .a_bcast   (a_cur),
            .carry_in  ((g == 0) ? word_type'(0) : cout[(g == 0) ? 0 : g-1]),
            .upper_acc ((g == CellCount-1) ? word_type'(0)
                                           : acc[(g == CellCount-1) ? g : g+1]),
            .acc       (acc[g]),
            .carry_out (cout[g])
         );
      end
   endgenerate

   always_comb begin
      st_in   = st_ff;
      load_in = load_ff;
      row_in  = row_ff;
      step_in = step_ff;
      out_in  = out_ff;
      unique case (st_ff)
         ST_LOAD: begin
            if (accept) begin
               if (load_ff < (IdxBits+1)'(OpWords)) load_in = load_ff + 1'b1;
               if (req_last_pair) begin
                  st_in   = ST_MUL;
                  row_in  = '0;
                  step_in = '0;
               end
            end
         end
         ST_MUL: begin
            // mac steps drain carries into the spare top cell, then a shift
            if (step_ff == (IdxBits+1)'(OpWords+1)) begin
               step_in = '0;
               if (row_ff == (IdxBits+1)'(OpWords-1)) begin
                  st_in  = ST_OUT;
                  out_in = '0;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (out_ff == (PIdxBits+1)'(ProdWords-1)) st_in = ST_DONE;
            out_in = out_ff + 1'b1;
         end
         ST_DONE: begin
            st_in   = ST_LOAD;
            load_in = '0;
         end
         default: st_in = ST_LOAD;
      endcase
   end

   // words of the final product: low_ff then the shifted acc row
   word_type final_w [ProdWords];
   always_comb begin
      for (int k = 0; k < OpWords; k++) begin
         final_w[k]         = low_ff[k];
         final_w[OpWords+k] = acc[k];
      end
   end

   always_comb begin
      used_in = used_ff;
      if (st_ff == ST_MUL && st_in == ST_OUT) used_in = '0;
      else if (st_ff == ST_OUT && final_w[out_ff[PIdxBits-1:0]] != '0)
         used_in = UsedBits'(out_ff) + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_LOAD;
         load_ff <= '0;
         row_ff  <= '0;
         step_ff <= '0;
         out_ff  <= '0;
         used_ff <= '0;
      end else begin
         st_ff   <= st_in;
         load_ff <= load_in;
         row_ff  <= row_in;
         step_ff <= step_in;
         out_ff  <= out_in;
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && load_ff < (IdxBits+1)'(OpWords)) begin
         a_ff[load_ff[IdxBits-1:0]] <= req_a_word;
         b_ff[load_ff[IdxBits-1:0]] <= req_b_word;
      end
      // short operand: zero the rest at the final pair
      if (accept && req_last_pair) begin
         for (int k = 0; k < OpWords; k++) begin
            if ((IdxBits+1)'(k) > load_ff || (load_ff == (IdxBits+1)'(OpWords) && 1'b0)) begin
               a_ff[k] <= '0;
               b_ff[k] <= '0;
            end
         end
      end
      // retire the low word on the shift of a row
      if (st_ff == ST_MUL && step_ff == (IdxBits+1)'(OpWords+1)
          && row_ff < (IdxBits+1)'(OpWords))
         low_ff[row_ff[IdxBits-1:0]] <= acc[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (st_ff == ST_OUT);
      end
      rsp_product_word <= final_w[out_ff[PIdxBits-1:0]];
      rsp_last_word    <= (out_ff == (PIdxBits+1)'(ProdWords-1));
      rsp_used_words   <= (out_ff == (PIdxBits+1)'(ProdWords-1)) ? used_in : '0;
   end
endmodule
`default_nettype wire

// ----- sim/tb_karatsuba_bignum_multiply_top.sv -----
// Self-checking bench for the multi-word multiplier: streams operand words, predicts the
// product with a wide multiply, and checks every product word. Depends on kbm_pkg and the top.
`timescale 1ns / 1ps
module tb_karatsuba_bignum_multiply_top;
   import kbm_pkg::*;

   localparam int OpBits    = OpWords * WordBits;
   localparam int ProdBits  = ProdWords * WordBits;
   localparam int CycleLimit = 400000;

   typedef struct packed {
      word_type a;
      word_type b;
      logic     last;
   } pair_type;

   typedef struct packed {
      word_type   word;
      logic       last;
      logic [5:0] used;
   } prod_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   word_type req_a_word = '0;
   word_type req_b_word = '0;
   logic req_last_pair = 1'b0;
   logic rsp_valid;
   word_type rsp_product_word;
   logic rsp_last_word;
   logic [5:0] rsp_used_words;

   pair_type pending_pairs[$];
   prod_word_type expected_words[$];
   int errors = 0;
   int cycles = 0;
   int gap_left = 0;
   int burst_left = 0;
   bit stim_done = 0;

   // operand image kept by the predictor
   logic [OpBits-1:0] op_a, op_b;
   int load_pos = 0;

   karatsuba_bignum_multiply_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_word(req_a_word), .req_b_word(req_b_word), .req_last_pair(req_last_pair),
      .rsp_valid(rsp_valid), .rsp_product_word(rsp_product_word),
      .rsp_last_word(rsp_last_word), .rsp_used_words(rsp_used_words)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // words beyond the operand length are dropped; unloaded words count as zero
   task automatic predict_pair(input pair_type p);
      logic [ProdBits-1:0] prod;
      int used;
      prod_word_type w;
      if (load_pos < OpWords) begin
         op_a[load_pos*WordBits +: WordBits] = p.a;
         op_b[load_pos*WordBits +: WordBits] = p.b;
         load_pos++;
      end
      if (p.last) begin
         for (int i = load_pos; i < OpWords; i++) begin
            op_a[i*WordBits +: WordBits] = '0;
            op_b[i*WordBits +: WordBits] = '0;
         end
         load_pos = 0;
         prod = ProdBits'(op_a) * ProdBits'(op_b);
         used = ProdWords;
         while (used > 0 && prod[(used-1)*WordBits +: WordBits] == '0) used--;
         for (int i = 0; i < ProdWords; i++) begin
            w.word = prod[i*WordBits +: WordBits];
            w.last = (i == ProdWords - 1);
            w.used = w.last ? 6'(used) : 6'd0;
            expected_words.push_back(w);
         end
      end
   endtask

   function automatic word_type rand_word(input int kind);
      case (kind)
         0: return '0;
         1: return '1;
         2: return word_type'($urandom_range(0, 3));
         default: return $urandom();
      endcase
   endfunction

   task automatic push_operands(input int len, input int kind);
      pair_type p;
      for (int i = 0; i < len; i++) begin
         p.a = rand_word(kind);
         p.b = rand_word(kind);
         p.last = (i == len - 1);
         pending_pairs.push_back(p);
      end
   endtask

   // directed, then random operand sets
   initial begin
      pair_type p;
      int left;
      push_operands(OpWords, 1);        // all ones squared
      push_operands(OpWords, 0);        // zero product
      push_operands(1, 3);              // short operand
      push_operands(OpWords + 3, 3);    // too many pairs
      for (int i = 0; i < OpWords; i++) begin
         // small repeating a words against random b words
         p.a = word_type'(i % 8 + 5); p.b = $urandom(); p.last = (i == OpWords - 1);
         pending_pairs.push_back(p);
      end
      left = 430 - 2 * OpWords - 1 - (OpWords + 3) - OpWords;
      while (left > 0) begin
         int len;
         case ($urandom_range(0, 9))
            0: len = $urandom_range(1, OpWords - 1);
            1: len = $urandom_range(OpWords + 1, OpWords + 4);
            default: len = OpWords;
         endcase
         push_operands(len, $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : 3);
         left -= len;
      end
   end

   // driver: bursts with gaps
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_pair({req_a_word, req_b_word, req_last_pair});
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
               p_drive();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               start <= 1'b0;
               stim_done <= 1'b1;
            end
         end
      end
   end

   task automatic p_drive();
      pair_type p;
      p = pending_pairs.pop_front();
      start <= 1'b1;
      req_a_word <= p.a;
      req_b_word <= p.b;
      req_last_pair <= p.last;
   endtask

   // monitor
   always @(posedge clock) begin
      prod_word_type w;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            report("unexpected word", rsp_product_word, '0);
         end else begin
            w = expected_words.pop_front();
            if (rsp_product_word !== w.word) report("product_word", rsp_product_word, w.word);
            if (rsp_last_word !== w.last) report("last_word", 32'(rsp_last_word), 32'(w.last));
            if (rsp_used_words !== w.used) report("used_words", 32'(rsp_used_words), 32'(w.used));
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (!(stim_done && expected_words.size() == 0) && cycles < CycleLimit)
         @(posedge clock);
      if (cycles >= CycleLimit) begin
         $display("DONE: errors detected");
      end else begin
         repeat (400) @(posedge clock);
         if (errors == 0) begin
            $display("DONE: 0 errors");
         end else begin
            $display("DONE: errors detected");
         end
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
sv/kbm_pkg.sv
sv/kbm_cell.sv
sv/karatsuba_bignum_multiply_top.sv
sim/tb_karatsuba_bignum_multiply_top.sv
